FILE: hw/rtl/fhe_pkg.sv
`timescale 1ns / 1ps

package fhe_pkg;

  // strip geometry
  localparam int NUM_CELLS = 122;
  localparam int CELL_W    = $clog2(NUM_CELLS);

  // register widths and reset values
  localparam int FH_W      = 12;
  localparam int RATE_W    = 8;
  localparam int INT_W     = 9;
  localparam int FH_MAX    = 4095;
  localparam int FH_RST    = 50;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // register indexes, byte address is index times four
  localparam logic [1:0] REG_FLAME_HEIGHT = 2'd0;
  localparam logic [1:0] REG_SPARK_RATE   = 2'd1;
  localparam logic [1:0] REG_INTENSITY    = 2'd2;

  localparam logic [FH_W-1:0]   FH_RST_VAL   = FH_W'(FH_RST);
  localparam logic [RATE_W-1:0] RATE_RST_VAL = 8'd100;
  localparam logic [INT_W-1:0]  INT_RST_VAL  = 9'd256;

  // cooling span minus one, flame_height*10/NUM_CELLS + 1
  localparam int SPAN_W = $clog2((FH_MAX * 10) / NUM_CELLS + 2);
  localparam logic [SPAN_W-1:0] SPAN_M1_RST = SPAN_W'((FH_RST * 10) / NUM_CELLS + 1);

  // reciprocal for the divide by NUM_CELLS, exact for 16-bit dividends
  localparam int    SPAN_X_W   = 16;
  localparam int    SPAN_SH    = SPAN_X_W + 1 + CELL_W;
  localparam int    SPAN_MUL_W = SPAN_SH - CELL_W + 1;
  localparam longint SPAN_MUL  =
    ((longint'(1) <<< SPAN_SH) + longint'(NUM_CELLS) - 1) / longint'(NUM_CELLS);

  typedef struct packed {
    logic [SPAN_W-1:0] span_m1;
    logic [RATE_W-1:0] spark_rate;
    logic [INT_W-1:0]  intensity;
  } cfg_t;

  typedef struct packed {
    logic [7:0] heat;
    logic [6:0] cell_res;
    logic       frame_end;
  } heat_word_t;

endpackage

FILE: hw/rtl/fhe_cfg.sv
`timescale 1ns / 1ps

module fhe_cfg import fhe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [ADDR_W-1:0] paddr_i,
  input  logic [DATA_W-1:0] pwdata_i,
  output logic [DATA_W-1:0] prdata_o,
  output logic              pready_o,
  output cfg_t              cfg_o
);

  localparam int         PROD_W           = SPAN_X_W + SPAN_MUL_W;

  logic [FH_W-1:0]     fh_q;
  logic [RATE_W-1:0]   rate_q;
  logic [INT_W-1:0]    int_q;
  logic [SPAN_W-1:0]   span_m1_q;
  logic [SPAN_W-1:0]   span_m1_d;
  logic [SPAN_X_W-1:0] fh_x10;
  logic [PROD_W-1:0]   span_prod;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign reg_idx  = paddr_i[3:2];
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  // span is worked out once per write so the item path sees a plain register
  assign fh_x10    = SPAN_X_W'(pwdata_i[FH_W-1:0]) * SPAN_X_W'(10);
  assign span_prod = PROD_W'(fh_x10) * PROD_W'(SPAN_MUL);
  assign span_m1_d = SPAN_W'(span_prod >> SPAN_SH) + SPAN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fh_q      <= FH_RST_VAL;
      rate_q    <= RATE_RST_VAL;
      int_q     <= INT_RST_VAL;
      span_m1_q <= SPAN_M1_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_FLAME_HEIGHT: begin
          fh_q      <= pwdata_i[FH_W-1:0];
          span_m1_q <= span_m1_d;
        end
        REG_SPARK_RATE: rate_q <= pwdata_i[RATE_W-1:0];
        REG_INTENSITY:  int_q  <= pwdata_i[INT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FLAME_HEIGHT: prdata_o = DATA_W'(fh_q);
      REG_SPARK_RATE:   prdata_o = DATA_W'(rate_q);
      REG_INTENSITY:    prdata_o = DATA_W'(int_q);
      default:          prdata_o = '0;
    endcase
  end

  assign cfg_o.span_m1    = span_m1_q;
  assign cfg_o.spark_rate = rate_q;
  assign cfg_o.intensity  = int_q;

endmodule

FILE: hw/rtl/fhe_heat.sv
`timescale 1ns / 1ps

module fhe_heat import fhe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] cool_amount_i,
  input  logic [7:0] spark_roll_i,
  input  logic [2:0] spark_cell_i,
  input  logic [7:0] spark_heat_i,
  input  cfg_t       cfg_i,
  output logic       hw_valid_o,
  input  logic       hw_stall_i,
  output heat_word_t hw_o
);

  localparam int DIV3_MUL = 683;
  localparam int DIV3_SH  = 11;

  // heat store, one byte per cell, plus a written flag per cell
  logic [7:0]           heat_mem [NUM_CELLS];
  logic [NUM_CELLS-1:0] written_q;

  logic [CELL_W-1:0] k_q;

  // fetch stage
  logic              a_valid_q;
  logic [7:0]        a_cool_q;
  logic [7:0]        a_roll_q;
  logic [2:0]        a_cell_q;
  logic [7:0]        a_sheat_q;
  logic [CELL_W-1:0] a_k_q;
  logic [7:0]        a_heat_q;
  logic              a_hit_q;

  // state carried from cell to cell
  logic [7:0] c1_q;
  logic [7:0] c2_q;
  logic       armed_q;
  logic [2:0] target_q;
  logic [7:0] add_q;

  logic       b_valid_q;
  heat_word_t b_word_q;

  logic       b_rdy;
  logic       a_rdy;
  logic       a_adv;
  logic       in_acc;
  logic       is_first;
  logic [7:0] h;
  logic [7:0] cd;
  logic [7:0] cooled;
  logic [9:0] sum;
  logic [19:0] prod3;
  logic [7:0] div3;
  logic [7:0] base;
  logic       armed;
  logic [2:0] target;
  logic [7:0] add;
  logic [7:0] fresh;

  assign b_rdy      = !b_valid_q || !hw_stall_i;
  assign a_rdy      = !a_valid_q || b_rdy;
  assign a_adv      = a_valid_q && b_rdy;
  assign in_acc     = in_valid_i && a_rdy;
  assign in_stall_o = !a_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= '0;
      a_valid_q <= 1'b0;
    end else begin
      if (a_rdy) a_valid_q <= in_valid_i;
      if (in_acc) k_q <= (k_q == CELL_W'(NUM_CELLS - 1)) ? '0 : k_q + CELL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_cool_q  <= cool_amount_i;
      a_roll_q  <= spark_roll_i;
      a_cell_q  <= spark_cell_i;
      a_sheat_q <= spark_heat_i;
      a_k_q     <= k_q;
      a_heat_q  <= heat_mem[k_q];
      a_hit_q   <= written_q[k_q];
    end
    if (a_adv) heat_mem[a_k_q] <= fresh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) written_q <= '0;
    else if (a_adv) written_q[a_k_q] <= 1'b1;
  end

  assign is_first = (a_k_q == '0);
  assign h        = a_hit_q ? a_heat_q : 8'd0;
  assign cd       = (16'(a_cool_q) > 16'(cfg_i.span_m1)) ? 8'(cfg_i.span_m1) : a_cool_q;
  assign cooled   = (h > cd) ? h - cd : 8'd0;

  // (c1 + 2*c2) / 3 through a reciprocal, exact below 2048
  assign sum   = 10'(c1_q) + {1'b0, c2_q, 1'b0};
  assign prod3 = 20'(sum) * 20'(DIV3_MUL);
  assign div3  = prod3[DIV3_SH +: 8];
  assign base  = (a_k_q <= CELL_W'(1)) ? cooled : div3;

  // spark settings are taken from the first cell of the frame
  assign armed  = is_first ? (a_roll_q < cfg_i.spark_rate) : armed_q;
  assign target = is_first ? ((a_cell_q == 3'd7) ? 3'd6 : a_cell_q) : target_q;
  assign add    = is_first ? a_sheat_q : add_q;
  assign fresh  = (armed && (a_k_q == CELL_W'(target))) ? base + add : base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q      <= '0;
      c2_q      <= '0;
      armed_q   <= 1'b0;
      target_q  <= '0;
      add_q     <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (b_rdy) b_valid_q <= a_valid_q;
      if (a_adv) begin
        c2_q <= c1_q;
        c1_q <= cooled;
        if (is_first) begin
          armed_q  <= armed;
          target_q <= target;
          add_q    <= add;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      b_word_q.heat      <= fresh;
      b_word_q.cell_res  <= 7'(a_k_q);
      b_word_q.frame_end <= (a_k_q == CELL_W'(NUM_CELLS - 1));
    end
  end

  assign hw_valid_o = b_valid_q;
  assign hw_o       = b_word_q;

endmodule

FILE: hw/rtl/fhe_colour.sv
`timescale 1ns / 1ps

module fhe_colour import fhe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       hw_valid_i,
  output logic       hw_stall_o,
  input  heat_word_t hw_i,
  input  cfg_t       cfg_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o,
  output logic [6:0] cell_res_o,
  output logic       frame_end_o
);

  localparam int REC255_MUL = 65794;
  localparam int REC255_SH  = 24;

  // round(h*191/255), reciprocal exact for dividends below 66052
  function automatic logic [7:0] heat_level(logic [7:0] hv);
    logic [15:0] num;
    logic [32:0] prod;
    num  = 16'(hv) * 16'd191 + 16'd127;
    prod = 33'(num) * 33'(REC255_MUL);
    return prod[REC255_SH +: 8];
  endfunction

  function automatic logic [7:0] scale(logic [7:0] v, logic [INT_W-1:0] k);
    logic [16:0] p;
    p = 17'(v) * 17'(k);
    return p[16] ? 8'hFF : p[15:8];
  endfunction

  logic       c_valid_q;
  logic [7:0] c_r_q;
  logic [7:0] c_g_q;
  logic [7:0] c_b_q;
  logic [6:0] c_cell_q;
  logic       c_end_q;

  logic       out_valid_q;
  logic [7:0] red_q;
  logic [7:0] green_q;
  logic [7:0] blue_q;
  logic [6:0] cell_q;
  logic       end_q;

  logic       d_rdy;
  logic       c_rdy;
  logic [7:0] t;
  logic [7:0] ramp;
  logic [7:0] r_d;
  logic [7:0] g_d;
  logic [7:0] b_d;

  assign d_rdy      = !out_valid_q || !out_stall_i;
  assign c_rdy      = !c_valid_q || d_rdy;
  assign hw_stall_o = !c_rdy;

  assign t    = heat_level(hw_i.heat);
  assign ramp = {t[5:0], 2'b00};

  // three heat bands: hottest, middle, coolest
  always_comb begin
    if (t > 8'h80) begin
      r_d = 8'hFF;
      g_d = 8'hFF;
      b_d = ramp;
    end else if (t > 8'h40) begin
      r_d = ramp;
      g_d = 8'hFF;
      b_d = 8'h00;
    end else begin
      r_d = 8'h00;
      g_d = ramp;
      b_d = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (c_rdy) c_valid_q <= hw_valid_i;
      if (d_rdy) out_valid_q <= c_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hw_valid_i && c_rdy) begin
      c_r_q    <= r_d;
      c_g_q    <= g_d;
      c_b_q    <= b_d;
      c_cell_q <= hw_i.cell_res;
      c_end_q  <= hw_i.frame_end;
    end
    if (c_valid_q && d_rdy) begin
      red_q   <= scale(c_r_q, cfg_i.intensity);
      green_q <= scale(c_g_q, cfg_i.intensity);
      blue_q  <= scale(c_b_q, cfg_i.intensity);
      cell_q  <= c_cell_q;
      end_q   <= c_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign cell_res_o  = cell_q;
  assign frame_end_o = end_q;

endmodule

FILE: hw/rtl/led_fire_heat_effect.sv
`timescale 1ns / 1ps
// path: an accepted word passes the fetch, heat word, colour and output registers
// throughput: one word per cycle unless stalled, set by the single read and single
//   write per cycle on the heat store (read on accept, written back one stage later)
// reset: asynchronous, clears control state and the per-cell written flags at once,
//   so the heat store reads as zero with no clearing pass; registers return to defaults

module led_fire_heat_effect import fhe_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        cool_amount_i,
  input  logic [7:0]        spark_roll_i,
  input  logic [2:0]        spark_cell_i,
  input  logic [7:0]        spark_heat_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [6:0]        cell_res_o,
  output logic              frame_end_o
);

  cfg_t       cfg;
  heat_word_t hw;
  logic       hw_valid;
  logic       hw_stall;

  fhe_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  fhe_heat u_heat (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cool_amount_i (cool_amount_i),
    .spark_roll_i  (spark_roll_i),
    .spark_cell_i  (spark_cell_i),
    .spark_heat_i  (spark_heat_i),
    .cfg_i         (cfg),
    .hw_valid_o    (hw_valid),
    .hw_stall_i    (hw_stall),
    .hw_o          (hw)
  );

  fhe_colour u_colour (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .hw_valid_i  (hw_valid),
    .hw_stall_o  (hw_stall),
    .hw_i        (hw),
    .cfg_i       (cfg),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .cell_res_o  (cell_res_o),
    .frame_end_o (frame_end_o)
  );

endmodule
